@@ rtl/rgbla_pkg.sv @@
package rgbla_pkg;

	// Animation mode codes.
	localparam logic [1:0] MODE_OFF     = 2'd0;
	localparam logic [1:0] MODE_ROTATE  = 2'd1;
	localparam logic [1:0] MODE_BREATHE = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] REG_ANIM_MODE  = 3'd0;
	localparam logic [2:0] REG_PERIOD_MS  = 3'd1;
	localparam logic [2:0] REG_STEP_SIZE  = 3'd2;
	localparam logic [2:0] REG_BASE_HUE   = 3'd3;
	localparam logic [2:0] REG_BASE_SAT   = 3'd4;
	localparam logic [2:0] REG_PEAK_VALUE = 3'd5;

	// Operations of the shared multiply and divide-by-100 unit, in issue order.
	localparam logic [2:0] OP_RAMP    = 3'd0;
	localparam logic [2:0] OP_BLEND_R = 3'd1;
	localparam logic [2:0] OP_BLEND_G = 3'd2;
	localparam logic [2:0] OP_BLEND_B = 3'd3;
	localparam logic [2:0] OP_SCALE_R = 3'd4;
	localparam logic [2:0] OP_SCALE_G = 3'd5;
	localparam logic [2:0] OP_SCALE_B = 3'd6;

	localparam logic [8:0]  HUE_MAX     = 9'd359;
	localparam logic [15:0] HUE_WRAP    = 16'd360;
	localparam logic [6:0]  PCT_MAX     = 7'd100;
	localparam logic [7:0]  LEVEL_MAX   = 8'd255;
	localparam logic [8:0]  RAMP_SLOPE  = 9'd425;
	// n / 100 == (n * 5243) >> 19 for every n below 43699.
	localparam logic [12:0] RECIP_100   = 13'd5243;
	localparam int          RECIP_SHIFT = 19;

	typedef struct packed {
		logic [1:0]  anim_mode;
		logic [15:0] period_ms;
		logic [7:0]  step_size;
		logic [8:0]  base_hue;
		logic [6:0]  base_saturation;
		logic [6:0]  peak_value;
	} cfg_t;

	typedef struct packed {
		logic       load;
		logic       check;
		logic       mul;
		logic       div;
		logic       emit;
		logic [2:0] op;
	} cmd_t;

	typedef struct packed {
		logic hit;
	} stat_t;

endpackage

@@ rtl/rgbla_ctrl.sv @@
module rgbla_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	input  rgbla_pkg::stat_t stat,
	output rgbla_pkg::cmd_t  cmd
);
	import rgbla_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_next;
	logic [2:0] op_q;
	logic       out_valid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.op = op_q;
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_next = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_next = stat.hit ? ST_MUL : ST_IDLE;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_next = ST_DIV;
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				state_next = (op_q == OP_SCALE_B) ? ST_DONE : ST_MUL;
			end
			ST_DONE: begin
				if (!out_valid_q || m_tready) begin
					cmd.emit = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= OP_RAMP;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (state_q == ST_CHECK) begin
				op_q <= OP_RAMP;
			end else if (state_q == ST_DIV && op_q != OP_SCALE_B) begin
				op_q <= op_q + 3'd1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/rgbla_dp.sv @@
module rgbla_dp #(
	parameter int TIME_BITS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  rgbla_pkg::cfg_t  cfg,
	input  rgbla_pkg::cmd_t  cmd,
	output rgbla_pkg::stat_t stat,
	input  logic [31:0]      now_ms,
	output logic [23:0]      rgb
);
	import rgbla_pkg::*;

	logic [63:0]          now_wide;
	logic [TIME_BITS-1:0] now_q;
	logic [TIME_BITS-1:0] rot_last_q;
	logic [TIME_BITS-1:0] br_last_q;
	logic [TIME_BITS-1:0] rot_elapsed;
	logic [TIME_BITS-1:0] br_elapsed;
	logic [15:0]          rot_hue_q;
	logic [7:0]           br_level_q;
	logic                 br_falling_q;
	logic                 is_rot;
	logic                 is_br;

	logic [8:0]  h_q;
	logic [6:0]  s_q;
	logic [6:0]  v_q;
	logic [6:0]  inv;
	logic [7:0]  ramp_q;
	logic [15:0] prod_q;
	logic [7:0]  col_q [3];
	logic [23:0] rgb_q;

	logic [8:0]  hue_base;
	logic [8:0]  d_full;
	logic [7:0]  c_base [3];
	logic [8:0]  mul_a;
	logic [6:0]  mul_b;
	logic [28:0] quot_full;
	logic [7:0]  quot;
	logic [1:0]  ch_blend;
	logic [1:0]  ch_scale;
	logic [8:0]  rise_sum;
	logic [15:0] rot_hue_base;

	assign now_wide = {32'd0, now_ms};

	assign is_rot = (cfg.anim_mode == MODE_ROTATE);
	assign is_br = (cfg.anim_mode == MODE_BREATHE);
	assign rot_elapsed = now_q - rot_last_q;
	assign br_elapsed = now_q - br_last_q;
	assign stat.hit = (is_rot && rot_elapsed >= TIME_BITS'(cfg.period_ms)) ||
		(is_br && br_elapsed >= TIME_BITS'(cfg.period_ms));

	assign rot_hue_base = (rot_hue_q > HUE_WRAP) ? 16'd0 : rot_hue_q;
	assign rise_sum = {1'b0, br_level_q} + {1'b0, cfg.step_size};

	// Animation state; it moves only when the active mode fires.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_last_q <= '0;
			rot_hue_q <= '0;
			br_last_q <= '0;
			br_level_q <= '0;
			br_falling_q <= 1'b0;
		end else if (cmd.check && stat.hit) begin
			if (is_rot) begin
				rot_last_q <= now_q;
				rot_hue_q <= rot_hue_base + {8'd0, cfg.step_size};
			end else begin
				br_last_q <= now_q;
				if (!br_falling_q) begin
					if (rise_sum >= {2'b00, cfg.peak_value}) begin
						br_level_q <= {1'b0, cfg.peak_value};
						br_falling_q <= 1'b1;
					end else begin
						br_level_q <= rise_sum[7:0];
					end
				end else if (cfg.step_size >= br_level_q) begin
					br_level_q <= '0;
					br_falling_q <= 1'b0;
				end else begin
					br_level_q <= br_level_q - cfg.step_size;
				end
			end
		end
	end

	// Color inputs are clamped as they are captured.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			now_q <= now_wide[TIME_BITS-1:0];
		end
		if (cmd.check) begin
			if (is_rot) begin
				h_q <= (rot_hue_q > {7'd0, HUE_MAX}) ? HUE_MAX : rot_hue_q[8:0];
				s_q <= PCT_MAX;
				v_q <= PCT_MAX;
			end else begin
				h_q <= (cfg.base_hue > HUE_MAX) ? HUE_MAX : cfg.base_hue;
				s_q <= (cfg.base_saturation > PCT_MAX) ? PCT_MAX : cfg.base_saturation;
				v_q <= (br_level_q > {1'b0, PCT_MAX}) ? PCT_MAX : br_level_q[6:0];
			end
		end
	end

	assign inv = PCT_MAX - s_q;

	// Six hue segments, each a flat, rising or falling edge per channel.
	always_comb begin
		if (h_q < 9'd61) begin
			hue_base = 9'd0;
			c_base[0] = LEVEL_MAX;
			c_base[1] = ramp_q;
			c_base[2] = 8'd0;
		end else if (h_q < 9'd121) begin
			hue_base = 9'd60;
			c_base[0] = LEVEL_MAX - ramp_q;
			c_base[1] = LEVEL_MAX;
			c_base[2] = 8'd0;
		end else if (h_q < 9'd181) begin
			hue_base = 9'd120;
			c_base[0] = 8'd0;
			c_base[1] = LEVEL_MAX;
			c_base[2] = ramp_q;
		end else if (h_q < 9'd241) begin
			hue_base = 9'd180;
			c_base[0] = 8'd0;
			c_base[1] = LEVEL_MAX - ramp_q;
			c_base[2] = LEVEL_MAX;
		end else if (h_q < 9'd301) begin
			hue_base = 9'd240;
			c_base[0] = ramp_q;
			c_base[1] = 8'd0;
			c_base[2] = LEVEL_MAX;
		end else begin
			hue_base = 9'd300;
			c_base[0] = LEVEL_MAX;
			c_base[1] = 8'd0;
			c_base[2] = LEVEL_MAX - ramp_q;
		end
	end

	assign d_full = h_q - hue_base;
	assign ch_blend = 2'(cmd.op - OP_BLEND_R);
	assign ch_scale = 2'(cmd.op - OP_SCALE_R);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op) inside
			OP_RAMP: begin
				mul_a = RAMP_SLOPE;
				mul_b = {1'b0, d_full[5:0]};
			end
			OP_BLEND_R, OP_BLEND_G, OP_BLEND_B: begin
				mul_a = {1'b0, LEVEL_MAX - c_base[ch_blend]};
				mul_b = inv;
			end
			OP_SCALE_R, OP_SCALE_G, OP_SCALE_B: begin
				mul_a = {1'b0, col_q[ch_scale]};
				mul_b = v_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign quot_full = {13'd0, prod_q} * {16'd0, RECIP_100};
	assign quot = quot_full[RECIP_SHIFT +: 8];

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= mul_a * {9'd0, mul_b};
		end
		if (cmd.div) begin
			case (cmd.op) inside
				OP_RAMP: ramp_q <= quot;
				OP_BLEND_R, OP_BLEND_G, OP_BLEND_B:
					col_q[ch_blend] <= c_base[ch_blend] + quot;
				OP_SCALE_R, OP_SCALE_G, OP_SCALE_B:
					col_q[ch_scale] <= quot;
				default: ramp_q <= ramp_q;
			endcase
		end
		if (cmd.emit) begin
			rgb_q <= {col_q[2], col_q[1], col_q[0]};
		end
	end

	assign rgb = rgb_q;

endmodule

@@ rtl/rgb_led_animation_engine_top.sv @@
// Accepts one timestamp item at a time: s_tready stays low until the period check finds
// no color due, or until the color goes to the output register, which waits while an
// earlier color is not yet taken. One shared 9x7 multiplier and a reciprocal divide-by-100
// serve seven multiply-then-divide operations (one hue ramp, three blends, three value
// scales). arst_n resets the controller, animation state and config registers.
module rgb_led_animation_engine_top #(
	parameter int TIME_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] now_ms
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] red_level, [15:8] green_level, [23:16] blue_level
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [15:0] cfg_wdata
);
	import rgbla_pkg::*;

	// Register bank. Writes to indexes past the last register are dropped.
	cfg_t  cfg_q;
	cmd_t  cmd;
	stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.anim_mode <= MODE_OFF;
			cfg_q.period_ms <= 16'd0;
			cfg_q.step_size <= 8'd1;
			cfg_q.base_hue <= 9'd0;
			cfg_q.base_saturation <= PCT_MAX;
			cfg_q.peak_value <= PCT_MAX;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_ANIM_MODE:  cfg_q.anim_mode <= cfg_wdata[1:0];
				REG_PERIOD_MS:  cfg_q.period_ms <= cfg_wdata;
				REG_STEP_SIZE:  cfg_q.step_size <= cfg_wdata[7:0];
				REG_BASE_HUE:   cfg_q.base_hue <= cfg_wdata[8:0];
				REG_BASE_SAT:   cfg_q.base_saturation <= cfg_wdata[6:0];
				REG_PEAK_VALUE: cfg_q.peak_value <= cfg_wdata[6:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// The controller sequences load, period check, the multiply and divide steps of the
	// seven operations and the hand-off to the output register.
	rgbla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the per-mode animation state, the color pipeline
	// registers and the output data register.
	rgbla_dp #(
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.cmd    (cmd),
		.stat   (stat),
		.now_ms (s_tdata),
		.rgb    (m_tdata)
	);

`ifndef SYNTH
	// Only one item is in work at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("item accepted while another is in work");

	// A new result only appears at the end of an item's work.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result raised while controller idle");
`endif

endmodule
